// File: src/fcsf_pkg.sv
// Shared types and constants for the float channel to SBUS frame encoder.
// Used by fcsf_scale and float_channels_to_sbus_frame_top; depends on nothing else.
package fcsf_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int FRAME_SLOTS  = 16;
    localparam int CH_W         = 11;
    localparam int MANT_W       = 24;
    localparam int PROD_W       = CH_W + MANT_W;
    localparam int FRAME_LEN    = 25;
    localparam int CHAN_BITS    = FRAME_SLOTS * CH_W;
    localparam int DATA_BYTES   = CHAN_BITS / 8;

    localparam logic [6:0] BYTE_LIMIT = 7'(2 + 4 * NUM_CHANNELS);

    localparam logic [7:0]      HEADER_RST = 8'h0F;
    localparam logic [7:0]      FOOTER_RST = 8'h00;
    localparam logic [CH_W-1:0] FS_RST     = 11'd2000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HEADER = 2'd0;
    localparam logic [1:0] CFG_FOOTER = 2'd1;
    localparam logic [1:0] CFG_FS     = 2'd2;

    // Packet status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_MAGC = 2'd1;
    localparam logic [1:0] STAT_TOO_MANY = 2'd2;

    typedef struct packed {
        logic            start;
        logic [31:0]     bits;
        logic [CH_W-1:0] fs;
    } t_scale_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_scale_stat;

endpackage

// File: src/fcsf_scale.sv
// Bit-serial scaler: clamps an IEEE single value to 0..1, multiplies it by the
// full-scale setting, rounds to 24 significant bits and truncates to a channel value.
// Depends on fcsf_pkg.
module fcsf_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fcsf_pkg::t_scale_req       i_req,
    output fcsf_pkg::t_scale_stat      o_stat,
    output logic [fcsf_pkg::CH_W-1:0]  o_result
);

    localparam logic [2:0] SC_IDLE = 3'd0;
    localparam logic [2:0] SC_MUL  = 3'd1;
    localparam logic [2:0] SC_NORM = 3'd2;
    localparam logic [2:0] SC_FIN  = 3'd3;
    localparam logic [2:0] SC_DONE = 3'd4;

    localparam logic [3:0] NORM_MAX = 4'(fcsf_pkg::CH_W);

    logic [2:0]                      r_state, n_state;
    logic [fcsf_pkg::PROD_W-1:0]     r_acc, n_acc;
    logic [fcsf_pkg::MANT_W-1:0]     r_mant, n_mant;
    logic [fcsf_pkg::CH_W-1:0]       r_fs, n_fs;
    logic [3:0]                      r_step, n_step;
    logic [7:0]                      r_s, n_s;
    logic [fcsf_pkg::CH_W-1:0]       r_res, n_res;

    logic                            sign;
    logic [7:0]                      ex;
    logic [22:0]                     frac;
    logic                            round_up;
    logic [fcsf_pkg::MANT_W:0]       q;
    logic [fcsf_pkg::MANT_W:0]       qs;
    logic [7:0]                      t;

    assign sign = i_req.bits[31];
    assign ex   = i_req.bits[30:23];
    assign frac = i_req.bits[22:0];

    // After normalization the top bit sits at the MSB; the bits below the kept
    // 24 decide rounding to nearest, ties to even.
    assign round_up = r_acc[fcsf_pkg::CH_W-1]
                    & ((|r_acc[fcsf_pkg::CH_W-2:0]) | r_acc[fcsf_pkg::CH_W]);
    assign q  = {1'b0, r_acc[fcsf_pkg::PROD_W-1:fcsf_pkg::CH_W]}
              + {{fcsf_pkg::MANT_W{1'b0}}, round_up};
    // Net right shift of the rounded mantissa: exponent shift less the bits
    // already dropped by rounding.
    assign t  = r_s + {4'b0, r_step} - 8'(fcsf_pkg::CH_W);
    assign qs = q >> t[4:0];

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_mant  = r_mant;
        n_fs    = r_fs;
        n_step  = r_step;
        n_s     = r_s;
        n_res   = r_res;
        case (r_state)
            SC_IDLE: begin
                if (i_req.start) begin
                    if (ex == 8'hFF && frac != 23'd0) begin
                        n_res   = i_req.fs;
                        n_state = SC_DONE;
                    end else if (sign) begin
                        n_res   = '0;
                        n_state = SC_DONE;
                    end else if (ex >= 8'd127) begin
                        n_res   = i_req.fs;
                        n_state = SC_DONE;
                    end else if (ex == 8'd0) begin
                        n_res   = '0;
                        n_state = SC_DONE;
                    end else begin
                        n_acc   = '0;
                        n_mant  = {1'b1, frac};
                        n_fs    = i_req.fs;
                        n_step  = '0;
                        n_s     = 8'd150 - ex;
                        n_state = SC_MUL;
                    end
                end
            end
            SC_MUL: begin
                n_acc  = {r_acc[fcsf_pkg::PROD_W-2:0], 1'b0}
                       + (r_fs[fcsf_pkg::CH_W-1]
                          ? {{fcsf_pkg::CH_W{1'b0}}, r_mant} : '0);
                n_fs   = {r_fs[fcsf_pkg::CH_W-2:0], 1'b0};
                n_step = r_step + 4'd1;
                if (r_step == NORM_MAX - 4'd1) begin
                    n_step  = '0;
                    n_state = SC_NORM;
                end
            end
            SC_NORM: begin
                // A zero product stops after the longest possible shift.
                if (r_acc[fcsf_pkg::PROD_W-1] || r_step == NORM_MAX) begin
                    n_state = SC_FIN;
                end else begin
                    n_acc  = {r_acc[fcsf_pkg::PROD_W-2:0], 1'b0};
                    n_step = r_step + 4'd1;
                end
            end
            SC_FIN: begin
                n_res   = (t < 8'(fcsf_pkg::MANT_W + 1)) ? qs[fcsf_pkg::CH_W-1:0] : '0;
                n_state = SC_DONE;
            end
            SC_DONE: begin
                n_state = SC_IDLE;
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_mant <= n_mant;
        r_fs   <= n_fs;
        r_step <= n_step;
        r_s    <= n_s;
        r_res  <= n_res;
    end

    assign o_stat.busy = (r_state != SC_IDLE);
    assign o_stat.done = (r_state == SC_DONE);
    assign o_result    = r_res;

endmodule

// File: src/float_channels_to_sbus_frame_top.sv
// Float channel packet to SBUS frame encoder, top level.
// Depends on fcsf_pkg and fcsf_scale.
//
// Packet bytes are taken one per cycle, except that a byte that completes a
// channel value or ends the packet is held off while the bit-serial scaler is
// still working on the previous value; the scaler runs 11 multiply steps, up
// to 12 normalize steps, then rounds and writes back, and goes straight to its
// result for zero, negative, NaN or clamped inputs. Once a packet long enough
// for its count ends and its last value is written, the 25-byte frame leaves
// one byte per cycle while i_ready is high, from a shift register over the
// channel store; no packet bytes are taken until the last frame byte goes.
module float_channels_to_sbus_frame_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_last,
    output logic [1:0]  o_packet_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam logic [1:0] ST_RECV = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [4:0] LAST_IDX = 5'(fcsf_pkg::FRAME_LEN - 1);
    localparam logic [4:0] DATA_END = 5'(fcsf_pkg::DATA_BYTES);

    logic [1:0]                        r_state, n_state;
    logic [6:0]                        r_cnt, n_cnt;
    logic [7:0]                        r_decl, n_decl;
    logic                              r_magic, n_magic;
    logic [23:0]                       r_wa, n_wa;
    logic [fcsf_pkg::CHAN_BITS-1:0]    r_chan, n_chan;
    logic [4:0]                        r_emit, n_emit;
    logic [1:0]                        r_status, n_status;
    logic [3:0]                        r_pidx, n_pidx;
    logic [7:0]                        r_header;
    logic [7:0]                        r_footer;
    logic [fcsf_pkg::CH_W-1:0]         r_fs;

    logic                              in_acc;
    logic                              out_acc;
    logic [6:0]                        km2;
    logic                              in_body;
    logic                              word_end;
    logic [6:0]                        len;
    logic [6:0]                        lm2;
    logic                              drop;
    logic                              start_full;
    logic                              start_part;
    logic [31:0]                       part_word;

    fcsf_pkg::t_scale_req              sc_req;
    fcsf_pkg::t_scale_stat             sc_stat;
    logic [fcsf_pkg::CH_W-1:0]         sc_result;

    fcsf_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (sc_req),
        .o_stat   (sc_stat),
        .o_result (sc_result)
    );

    assign km2      = r_cnt - 7'd2;
    assign in_body  = (r_cnt >= 7'd2) && (r_cnt < fcsf_pkg::BYTE_LIMIT);
    assign word_end = in_body && (km2[1:0] == 2'd3);

    assign o_ready     = (r_state == ST_RECV) && !(sc_stat.busy && (word_end || i_last_byte));
    assign o_cfg_ready = 1'b1;
    assign o_valid     = (r_state == ST_EMIT);
    assign in_acc      = i_valid && o_ready;
    assign out_acc     = o_valid && i_ready;

    // Bytes past the limit are not counted in the packet length.
    assign len = (r_cnt < fcsf_pkg::BYTE_LIMIT) ? r_cnt + 7'd1 : r_cnt;
    assign lm2 = len - 7'd2;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_decl     = r_decl;
        n_magic    = r_magic;
        n_wa       = r_wa;
        n_chan     = r_chan;
        n_emit     = r_emit;
        n_status   = r_status;
        n_pidx     = r_pidx;
        drop       = 1'b0;
        start_full = 1'b0;
        start_part = 1'b0;
        part_word  = '0;

        if (in_acc) begin
            if (r_cnt == 7'd0) begin
                n_magic = (i_data_byte == r_header);
                n_decl  = '0;
                n_wa    = '0;
                n_chan  = '0;
            end else if (r_cnt == 7'd1) begin
                n_decl = i_data_byte;
            end else if (in_body) begin
                if (word_end) begin
                    n_wa       = '0;
                    start_full = ({4'b0, km2[5:2]} < r_decl);
                    n_pidx     = km2[5:2];
                end else begin
                    n_wa = {r_wa[15:0], i_data_byte};
                end
            end
            n_cnt = len;

            if (i_last_byte) begin
                n_cnt = '0;
                drop  = ({n_decl, 2'b00} > {3'b0, len});
                if (drop) begin
                    start_full = 1'b0;
                end else begin
                    // A value cut short takes zero for its missing low bytes.
                    case (lm2[1:0])
                        2'd1:    part_word = {n_wa[7:0], 24'b0};
                        2'd2:    part_word = {n_wa[15:0], 16'b0};
                        2'd3:    part_word = {n_wa[23:0], 8'b0};
                        default: part_word = '0;
                    endcase
                    if (len > 7'd2 && lm2[1:0] != 2'd0
                        && {4'b0, lm2[5:2]} < n_decl) begin
                        start_part = 1'b1;
                        n_pidx     = lm2[5:2];
                    end
                    if (!n_magic) begin
                        n_status = fcsf_pkg::STAT_BAD_MAGC;
                    end else if (n_decl > 8'(fcsf_pkg::NUM_CHANNELS)) begin
                        n_status = fcsf_pkg::STAT_TOO_MANY;
                    end else begin
                        n_status = fcsf_pkg::STAT_OK;
                    end
                    n_state = ST_WAIT;
                end
                n_wa = '0;
            end
        end

        if (sc_stat.done) begin
            for (int i = 0; i < fcsf_pkg::FRAME_SLOTS; i++) begin
                if (r_pidx == 4'(i)) begin
                    n_chan[i*fcsf_pkg::CH_W +: fcsf_pkg::CH_W] = sc_result;
                end
            end
        end

        if (r_state == ST_WAIT && !sc_stat.busy) begin
            n_state = ST_EMIT;
            n_emit  = '0;
        end

        if (out_acc) begin
            if (r_emit inside {[5'd1:DATA_END]}) begin
                n_chan = r_chan >> 8;
            end
            if (r_emit == LAST_IDX) begin
                n_state = ST_RECV;
                n_emit  = '0;
            end else begin
                n_emit = r_emit + 5'd1;
            end
        end
    end

    always_comb begin
        sc_req.start = start_full || start_part;
        sc_req.bits  = start_full ? {r_wa, i_data_byte} : part_word;
        sc_req.fs    = r_fs;
    end

    always_comb begin
        case (r_emit)
            5'd0:     o_frame_byte = r_header;
            LAST_IDX: o_frame_byte = r_footer;
            default: begin
                if (r_emit <= DATA_END && r_status == fcsf_pkg::STAT_OK) begin
                    o_frame_byte = r_chan[7:0];
                end else begin
                    o_frame_byte = 8'h00;
                end
            end
        endcase
    end

    assign o_frame_last    = (r_emit == LAST_IDX);
    assign o_packet_status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RECV;
            r_cnt    <= '0;
            r_emit   <= '0;
            r_header <= fcsf_pkg::HEADER_RST;
            r_footer <= fcsf_pkg::FOOTER_RST;
            r_fs     <= fcsf_pkg::FS_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_emit  <= n_emit;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    fcsf_pkg::CFG_HEADER: r_header <= i_cfg_data[7:0];
                    fcsf_pkg::CFG_FOOTER: r_footer <= i_cfg_data[7:0];
                    fcsf_pkg::CFG_FS:     r_fs     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_decl   <= n_decl;
        r_magic  <= n_magic;
        r_wa     <= n_wa;
        r_chan   <= n_chan;
        r_status <= n_status;
        r_pidx   <= n_pidx;
    end

    // The frame never starts while a channel value is still being scaled.
    a_emit_after_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !sc_stat.busy)
        else $error("frame emitted while scaler busy");

    // A new scale request is only issued to an idle scaler.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc_req.start |-> !sc_stat.busy)
        else $error("scale request while scaler busy");

    // Taking the final frame byte returns the block to packet reception.
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_frame_last) |=> (r_state == ST_RECV))
        else $error("block did not return to reception after frame");

    // Scaled values land only while a packet is open or its end is pending.
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc_stat.done |-> (r_state != ST_EMIT))
        else $error("channel write during frame emission");

endmodule

// File: tb/sv/fcsf_frame_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the float channel to SBUS frame encoder testbench: a packet
// parser and frame builder of its own plus the queue of expected frame bytes.
// Depends on fcsf_pkg for widths, register indexes and status codes.
package fcsf_frame_check_pkg;
    import fcsf_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } t_sbus_beat;

    class frame_scoreboard;
        logic [7:0]      header_reg;
        logic [7:0]      footer_reg;
        logic [CH_W-1:0] fs_reg;
        logic [6:0]      byte_cnt;
        logic [7:0]      decl_cnt;
        logic            magic_ok;
        logic [23:0]     word_acc;
        logic [CH_W-1:0] chan_val [FRAME_SLOTS];
        t_sbus_beat      frame_q [$];
        int              mismatches;
        int              beats_checked;
        int              frames_bad_magic;
        int              packets_dropped;

        function new();
            header_reg       = HEADER_RST;
            footer_reg       = FOOTER_RST;
            fs_reg           = FS_RST;
            byte_cnt         = '0;
            decl_cnt         = '0;
            magic_ok         = 1'b0;
            word_acc         = '0;
            foreach (chan_val[i]) chan_val[i] = '0;
            mismatches       = 0;
            beats_checked    = 0;
            frames_bad_magic = 0;
            packets_dropped  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [10:0] val);
            case (idx)
                CFG_HEADER: header_reg = val[7:0];
                CFG_FOOTER: footer_reg = val[7:0];
                CFG_FS:     fs_reg = val;
                default: ;
            endcase
        endfunction

        // Clamp to 0..1, multiply by full scale, keep 24 significant bits with
        // round to nearest even, then drop the fraction.
        function logic [CH_W-1:0] scaled_channel(logic [31:0] f);
            logic [7:0]  ex;
            logic [22:0] frac;
            logic [63:0] prod;
            logic [63:0] q;
            logic [63:0] rem;
            logic [63:0] half;
            int          len;
            int          d;
            int          sh;
            ex   = f[30:23];
            frac = f[22:0];
            if (ex == 8'hFF && frac != '0) return fs_reg;
            if (f[31]) return '0;
            if (ex >= 8'd127) return fs_reg;
            if (ex == 8'd0) return '0;
            prod = 64'(fs_reg) * 64'({1'b1, frac});
            len  = $clog2(prod + 64'd1);
            if (len > 24) begin
                d    = len - 24;
                q    = prod >> d;
                rem  = prod & ((64'd1 << d) - 64'd1);
                half = 64'd1 << (d - 1);
                if (rem > half || (rem == half && q[0])) q = q + 64'd1;
                prod = q << d;
            end
            sh = 150 - int'(ex);
            if (sh >= 40) return '0;
            prod = prod >> sh;
            return prod[CH_W-1:0];
        endfunction

        function void store_channel(int idx, logic [31:0] f);
            if (idx < int'(decl_cnt) && idx < NUM_CHANNELS) chan_val[idx] = scaled_channel(f);
        endfunction

        // Takes one accepted packet byte; on the last byte of a packet that
        // passes the length test, queues the 25 bytes of the frame.
        function void note_byte(logic [7:0] b, logic last);
            int                   k;
            int                   len;
            int                   rem;
            logic [31:0]          w;
            logic [1:0]           st;
            logic [CHAN_BITS-1:0] chan_bits;
            t_sbus_beat           beat;
            k = int'(byte_cnt);
            if (k == 0) begin
                foreach (chan_val[i]) chan_val[i] = '0;
                decl_cnt = '0;
                word_acc = '0;
                magic_ok = (b == header_reg);
            end else if (k == 1) begin
                decl_cnt = b;
            end else if (k < int'(BYTE_LIMIT)) begin
                if (((k - 2) & 3) == 3) begin
                    store_channel((k - 2) >> 2, {word_acc, b});
                    word_acc = '0;
                end else begin
                    word_acc = {word_acc[15:0], b};
                end
            end
            if (k < int'(BYTE_LIMIT)) byte_cnt = 7'(k + 1);
            if (!last) return;

            len      = int'(byte_cnt);
            byte_cnt = '0;
            if (4 * int'(decl_cnt) > len) begin
                word_acc = '0;
                packets_dropped++;
                return;
            end
            // A value cut short by the end of the packet gets zero low bytes.
            if (len > 2) begin
                rem = (len - 2) & 3;
                if (rem != 0) begin
                    w = {8'h00, word_acc};
                    w = w << (8 * (4 - rem));
                    store_channel((len - 2) >> 2, w);
                end
            end
            word_acc = '0;

            if (!magic_ok) st = STAT_BAD_MAGC;
            else if (int'(decl_cnt) > NUM_CHANNELS) st = STAT_TOO_MANY;
            else st = STAT_OK;
            if (st == STAT_BAD_MAGC) frames_bad_magic++;

            for (int ch = 0; ch < FRAME_SLOTS; ch++) chan_bits[ch*CH_W +: CH_W] = chan_val[ch];
            for (int i = 0; i < FRAME_LEN; i++) begin
                if (i == 0) beat.data = header_reg;
                else if (i == FRAME_LEN - 1) beat.data = footer_reg;
                else if (i <= DATA_BYTES && st == STAT_OK) beat.data = chan_bits[(i-1)*8 +: 8];
                else beat.data = 8'h00;
                beat.last   = (i == FRAME_LEN - 1);
                beat.status = st;
                frame_q.push_back(beat);
            end
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH %s", msg);
        endfunction

        function void check_beat(logic [7:0] b, logic last, logic [1:0] st);
            t_sbus_beat want;
            if (frame_q.size() == 0) begin
                note_mismatch($sformatf("frame byte %02h (last %0b status %0d) with no frame due",
                                        b, last, st));
                return;
            end
            want = frame_q.pop_front();
            if (want.data !== b || want.last !== last || want.status !== st)
                note_mismatch($sformatf(
                    "frame byte %0d: expected %02h last %0b status %0d, got %02h last %0b status %0d",
                    beats_checked, want.data, want.last, want.status, b, last, st));
            beats_checked++;
        endfunction

        function int pending();
            return frame_q.size();
        endfunction
    endclass

endpackage

// File: tb/sv/tb_float_channels_to_sbus_frame_top.sv
`timescale 1ns / 1ps
// Testbench for float_channels_to_sbus_frame_top: random packets over several
// register settings, frames checked byte by byte against the scoreboard.
// Depends on fcsf_pkg and fcsf_frame_check_pkg.
module tb_float_channels_to_sbus_frame_top;
    import fcsf_pkg::*;
    import fcsf_frame_check_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BYTES    = 48;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte     = '0;
    logic        i_last_byte     = 1'b0;
    logic        o_valid;
    logic        i_ready         = 1'b0;
    logic [7:0]  o_frame_byte;
    logic        o_frame_last;
    logic [1:0]  o_packet_status;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index     = '0;
    logic [10:0] i_cfg_data      = '0;

    frame_scoreboard sb;
    logic [7:0]      pkt_q [$];
    int              idle_pct      = 0;
    logic            long_hold_req = 1'b0;
    int              bytes_sent    = 0;
    int              cfg_writes    = 0;

    float_channels_to_sbus_frame_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_byte    (o_frame_byte),
        .o_frame_last    (o_frame_last),
        .o_packet_status (o_packet_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // A gap is drawn idle_pct percent of the time; when there is one, it is usually short.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= idle_pct) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // A value in (0,1) whose scaled product sits exactly halfway between two
    // 24-bit results under the current full scale, if the search finds one.
    function automatic logic [31:0] tie_value();
        logic [7:0]  ex;
        logic [23:0] mant;
        logic [63:0] prod;
        int          len;
        int          d;
        ex   = 8'($urandom_range(112, 126));
        mant = {1'b1, 23'($urandom())};
        for (int t = 0; t < 4096; t++) begin
            prod = 64'(sb.fs_reg) * 64'(mant);
            len  = $clog2(prod + 64'd1);
            if (len > 24) begin
                d = len - 24;
                if ((prod & ((64'd1 << d) - 64'd1)) == (64'd1 << (d - 1)))
                    return {1'b0, ex, mant[22:0]};
            end
            mant = {1'b1, mant[22:0] + 23'd1};
        end
        return {1'b0, ex, mant[22:0]};
    endfunction

    function automatic logic [31:0] rand_channel_bits();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 11))
            0:       return {r[31], 31'd0};
            1:       return {1'b1, r[30:0]};
            2:       return {r[31], 8'hFF, r[22:0] | 23'd1};
            3:       return r[0] ? 32'h7F80_0000 : 32'h3F80_0000;
            4:       return {1'b0, 8'($urandom_range(127, 254)), r[22:0]};
            5:       return {1'b0, 8'h00, r[22:0]};
            6:       return {1'b0, 8'($urandom_range(1, 111)), r[22:0]};
            7, 8:    return tie_value();
            default: return {1'b0, 8'($urandom_range(112, 126)), r[22:0]};
        endcase
    endfunction

    // Mostly well-formed packets; the rest are cut short, overlong, carry
    // undeclared values, a wrong magic byte or a random count.
    function automatic void make_packet();
        int          kind;
        int          n;
        int          total;
        logic [31:0] v;
        kind  = $urandom_range(0, 99);
        n     = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, 16);
        total = 2 + 4 * n;
        if (kind < 6) begin
            n     = $urandom_range(12, 16);
            total = int'(BYTE_LIMIT) + $urandom_range(1, 5);
        end else if (kind < 18 && n > 0) begin
            total = total - $urandom_range(1, 2);
        end else if (kind < 28) begin
            total = total + $urandom_range(1, 8);
        end else if (kind < 38) begin
            n     = $urandom_range(0, 255);
            total = $urandom_range(1, 12);
        end
        pkt_q.delete();
        if (kind >= 38 && kind < 48) pkt_q.push_back(sb.header_reg ^ 8'($urandom_range(1, 255)));
        else pkt_q.push_back(sb.header_reg);
        if (total > 1) pkt_q.push_back(8'(n));
        while (pkt_q.size() < total) begin
            v = rand_channel_bits();
            for (int i = 3; i >= 0; i--) begin
                if (pkt_q.size() < total) pkt_q.push_back(v[i*8 +: 8]);
            end
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_q.size(); i++) send_byte(pkt_q[i], i == pkt_q.size() - 1);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // Waits for every expected frame byte, then lets a dropped packet's
    // trailing work finish before the block is touched again.
    task automatic wait_quiet();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Frame receiver with random stalls and one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) sb.check_beat(o_frame_byte, o_frame_last, o_packet_status);
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready       = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready = 1'b0;
            end else begin
                stall_left = pick_gap();
                i_ready    = (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int          ph;
        int          phase_start;
        logic [7:0]  hdr;
        logic [7:0]  ftr;
        logic [10:0] fs;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        idle_pct = 20;

        // Directed packets under the reset register values.
        pkt_q = '{HEADER_RST};                      // magic byte only
        send_packet();
        pkt_q = '{HEADER_RST ^ 8'h01};              // wrong magic byte
        send_packet();
        pkt_q = '{HEADER_RST, 8'd2, 8'h3F, 8'h80, 8'h00, 8'h00,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF};      // 1.0 and a negative NaN
        send_packet();
        pkt_q = '{HEADER_RST, 8'd1, 8'h3F, 8'h00};  // value cut after two bytes
        send_packet();
        pkt_q = '{HEADER_RST, 8'd20};               // too many channels, too short
        send_packet();
        pkt_q = '{HEADER_RST, 8'd0, 8'h3F, 8'h80, 8'h00, 8'h00};  // undeclared value
        send_packet();
        i_valid = 1'b0;
        wait_quiet();

        for (ph = 1; ph <= 5; ph++) begin
            case (ph)
                1: begin
                    hdr = 8'hFF; ftr = 8'hFF; fs = 11'd2047; idle_pct = 30;
                end
                2: begin
                    hdr = 8'h00; ftr = 8'h00; fs = 11'd0; idle_pct = 30;
                end
                3: begin
                    hdr = 8'($urandom()); ftr = 8'($urandom()); fs = 11'd1; idle_pct = 0;
                end
                4: begin
                    hdr = 8'($urandom()); ftr = 8'($urandom()); fs = 11'($urandom());
                    idle_pct = 50;
                end
                default: begin
                    hdr = HEADER_RST; ftr = FOOTER_RST; fs = FS_RST; idle_pct = 20;
                end
            endcase
            write_reg(CFG_HEADER, {3'b000, hdr});
            write_reg(CFG_FOOTER, {3'b000, ftr});
            write_reg(CFG_FS, fs);
            i_cfg_valid = 1'b0;
            // Stall the frame side long enough that the input backs up.
            if (ph == 4) long_hold_req = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                make_packet();
                send_packet();
            end
            i_valid = 1'b0;
            wait_quiet();
        end

        $display("Sent %0d packet bytes over %0d register writes; %0d frames checked,",
                 bytes_sent, cfg_writes, sb.beats_checked / FRAME_LEN);
        $display("%0d of them with a bad magic byte, and %0d short packets dropped.",
                 sb.frames_bad_magic, sb.packets_dropped);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: sim.f
src/fcsf_pkg.sv
src/fcsf_scale.sv
src/float_channels_to_sbus_frame_top.sv
tb/sv/fcsf_frame_check_pkg.sv
tb/sv/tb_float_channels_to_sbus_frame_top.sv
